/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SWA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swa assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swa assertion failed: next-cycle implication");

`endif

/* rtl/core/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg
// Types, widths and constants of the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int SUM_WIDTH    = 22;
   localparam int FRAC_BITS    = 8;
   localparam int AVG_WIDTH    = 24;
   localparam int LEN_WIDTH    = 7;
   localparam int PTR_WIDTH    = $clog2(WINDOW_MAX);

   localparam int DIV_WIDTH     = SUM_WIDTH + FRAC_BITS;
   localparam int DIV_STEPS     = DIV_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(DIV_STEPS - 1);

   localparam logic [LEN_WIDTH-1:0] WINDOW_LEN_RESET = LEN_WIDTH'(5);
   localparam logic [LEN_WIDTH-1:0] WINDOW_MAX_LEN   = LEN_WIDTH'(WINDOW_MAX);
   localparam logic [LEN_WIDTH-1:0] WINDOW_MIN_LEN   = LEN_WIDTH'(1);

   localparam logic [DIV_WIDTH-1:0] AVG_POS_LIMIT = DIV_WIDTH'((1 << (AVG_WIDTH - 1)) - 1);
   localparam logic [DIV_WIDTH-1:0] AVG_NEG_LIMIT = DIV_WIDTH'(1 << (AVG_WIDTH - 1));
   localparam logic [AVG_WIDTH-1:0] AVG_MAX = {1'b0, {(AVG_WIDTH - 1){1'b1}}};
   localparam logic [AVG_WIDTH-1:0] AVG_MIN = {1'b1, {(AVG_WIDTH - 1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           first_of_sequence;
      logic                           last_of_sequence;
   } swa_req_type;

   typedef struct packed {
      logic signed [AVG_WIDTH-1:0] average;
      logic                        too_short;
   } swa_rsp_type;

   typedef struct packed {
      logic                        start;
      logic signed [SUM_WIDTH-1:0] dividend;
      logic [LEN_WIDTH-1:0]        divisor;
   } swa_div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [AVG_WIDTH-1:0] average;
   } swa_div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DELIVER
   } swa_state_type;

endpackage

/* rtl/core/swa_ring_ram.sv */
// ----------------------------------------------------------------------------
// swa_ring_ram
// Sample ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swa_ring_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [swa_pkg::PTR_WIDTH-1:0]     wr_addr,
   input  logic [swa_pkg::SAMPLE_WIDTH-1:0]  wr_data,
   input  logic                              rd_en,
   input  logic [swa_pkg::PTR_WIDTH-1:0]     rd_addr,
   output logic [swa_pkg::SAMPLE_WIDTH-1:0]  rd_data
);
   import swa_pkg::*;

   logic [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/swa_divider.sv */
// ----------------------------------------------------------------------------
// swa_divider
// Restoring divider, one quotient bit per cycle: sum * 256 / length,
// truncated toward zero and saturated to the average range.
// ----------------------------------------------------------------------------
module swa_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  swa_pkg::swa_div_req_type  div_req,
   output swa_pkg::swa_div_rsp_type  div_rsp
);
   import swa_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     finish_ff, finish_in;
   logic [DIV_CNT_WIDTH-1:0] count_ff, count_in;
   logic                     neg_ff, neg_in;
   logic [DIV_WIDTH-1:0]     quot_ff, quot_in;
   logic [LEN_WIDTH-1:0]     rem_ff, rem_in;
   logic [LEN_WIDTH-1:0]     divisor_ff, divisor_in;

   logic [SUM_WIDTH-1:0]     mag;
   logic [LEN_WIDTH:0]       trial;
   logic [LEN_WIDTH:0]       diff;
   logic                     fits;
   logic [AVG_WIDTH-1:0]     pos_avg;
   logic [AVG_WIDTH-1:0]     neg_avg;

   always_comb begin
      mag   = div_req.dividend[SUM_WIDTH-1] ? (~div_req.dividend + SUM_WIDTH'(1))
                                           : div_req.dividend;
      // bring down the next dividend bit
      trial = {rem_ff, quot_ff[DIV_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      finish_in  = 1'b0;
      count_in   = count_ff;
      neg_in     = neg_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         neg_in     = div_req.dividend[SUM_WIDTH-1];
         quot_in    = {mag, {FRAC_BITS{1'b0}}};
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DIV_WIDTH-2:0], fits};
         rem_in   = fits ? diff[LEN_WIDTH-1:0] : trial[LEN_WIDTH-1:0];
         count_in = count_ff + DIV_CNT_WIDTH'(1);
         if (count_ff == DIV_LAST) begin
            busy_in   = 1'b0;
            finish_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         finish_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         finish_ff <= finish_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   // clamp the magnitude, then restore the sign
   always_comb begin
      pos_avg = (quot_ff > AVG_POS_LIMIT) ? AVG_MAX : quot_ff[AVG_WIDTH-1:0];
      neg_avg = (quot_ff > AVG_NEG_LIMIT) ? AVG_MIN
                                          : (~quot_ff[AVG_WIDTH-1:0] + AVG_WIDTH'(1));
      div_rsp.done    = finish_ff;
      div_rsp.average = neg_ff ? neg_avg : pos_avg;
   end

endmodule

/* rtl/core/sliding_window_average.sv */
// ----------------------------------------------------------------------------
// sliding_window_average: moving average of a signed sample stream
// An averaged sample passes the window update, the divider and the output register in turn.
// Only one sample is in flight: a new one is taken once the last has been handled.
// Reset: synchronous; clears pointer, fill count, sum and handshakes; length back to 5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_average (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  swa_pkg::swa_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output swa_pkg::swa_rsp_type               rsp_data,
   input  logic                               csr_wr_en,
   input  logic [swa_pkg::LEN_WIDTH-1:0]      csr_wr_data
);
   import swa_pkg::*;

   swa_state_type                  state_ff, state_in;
   logic [LEN_WIDTH-1:0]           window_len_ff;
   logic [PTR_WIDTH-1:0]           wp_ff, wp_in;
   logic [LEN_WIDTH-1:0]           fill_ff, fill_in;
   logic [SUM_WIDTH-1:0]           sum_ff, sum_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           first_ff;
   logic                           last_ff;
   logic [LEN_WIDTH-1:0]           len_ff;
   swa_rsp_type                    pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   swa_rsp_type                    rsp_data_ff, rsp_data_in;

   logic                           accept;
   logic                           upd_en;
   logic                           div_start;
   logic                           rsp_load;
   logic                           slot_free;
   logic [LEN_WIDTH-1:0]           eff_len;
   logic [PTR_WIDTH-1:0]           rd_addr;
   logic [SAMPLE_WIDTH-1:0]        rd_data;
   logic [LEN_WIDTH-1:0]           fill0, fill1;
   logic [SUM_WIDTH-1:0]           sum0, sum1;
   logic [SUM_WIDTH-1:0]           x_ext, old_ext;
   logic                           produce;
   logic                           short_seq;
   swa_div_req_type                div_req;
   swa_div_rsp_type                div_rsp;

   // length as used: zero counts as one, beyond the ring saturates
   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = WINDOW_MIN_LEN;
      end else if (window_len_ff > WINDOW_MAX_LEN) begin
         eff_len = WINDOW_MAX_LEN;
      end else begin
         eff_len = window_len_ff;
      end
   end

   // oldest sample of the window, read while the transaction is taken
   assign rd_addr = wp_ff - eff_len[PTR_WIDTH-1:0];

   swa_ring_ram u_ring (
      .clock   (clock),
      .wr_en   (upd_en),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window update, valid in the cycle after acceptance
   always_comb begin
      x_ext   = {{(SUM_WIDTH - SAMPLE_WIDTH){x_ff[SAMPLE_WIDTH-1]}}, x_ff};
      old_ext = {{(SUM_WIDTH - SAMPLE_WIDTH){rd_data[SAMPLE_WIDTH-1]}}, rd_data};
      fill0   = first_ff ? '0 : fill_ff;
      sum0    = first_ff ? '0 : sum_ff;
      if (fill0 < len_ff) begin
         fill1   = fill0 + LEN_WIDTH'(1);
         sum1    = sum0 + x_ext;
         produce = (fill1 == len_ff);
      end else begin
         fill1   = fill0;
         sum1    = sum0 - old_ext + x_ext;
         produce = 1'b1;
      end
      short_seq = last_ff && (fill1 < len_ff);
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = sum1;
   assign div_req.divisor  = len_ff;

   swa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (short_seq) begin
               state_in = ST_DELIVER;
            end else if (produce) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      upd_en    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_UPDATE: begin
            upd_en    = 1'b1;
            div_start = produce && !short_seq;
         end
         ST_DIVIDE: begin
         end
         ST_DELIVER: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      pend_in = pend_ff;
      if (upd_en) begin
         wp_in = wp_ff + PTR_WIDTH'(1);
         // end of sequence: drop count and sum
         fill_in = last_ff ? '0 : fill1;
         sum_in  = last_ff ? '0 : sum1;
         if (short_seq) begin
            pend_in.average   = '0;
            pend_in.too_short = 1'b1;
         end
      end
      if (div_rsp.done) begin
         pend_in.average   = div_rsp.average;
         pend_in.too_short = 1'b0;
      end
   end

   // output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WINDOW_LEN_RESET;
         wp_ff         <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req_data.sample;
         first_ff <= req_data.first_of_sequence;
         last_ff  <= req_data.last_of_sequence;
         len_ff   <= eff_len;
      end
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SWA_ASSERT_IMPLIES(a_short_has_zero_avg, clock, reset, rsp_valid_ff && rsp_data_ff.too_short, rsp_data_ff.average == '0)
   `SWA_ASSERT_IMPLIES(a_div_done_in_divide, clock, reset, div_rsp.done, state_ff == ST_DIVIDE)
   `SWA_ASSERT_NEXT(a_accept_then_update, clock, reset, accept, state_ff == ST_UPDATE)
   `SWA_ASSERT_IMPLIES(a_fill_in_range, clock, reset, 1'b1, fill_ff <= WINDOW_MAX_LEN)

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for sliding_window_average
// Streams signed samples, first short directed sequences, then random
// sequences under several window lengths, and compares every average and
// too-short flag with a cycle-free predictor of the block.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swa_pkg::*;

   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1330;

   class moving_average_predictor;
      logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];
      logic [PTR_WIDTH-1:0]           wr_ptr;
      logic [LEN_WIDTH-1:0]           fill;
      logic [SUM_WIDTH-1:0]           sum;
      logic [LEN_WIDTH-1:0]           window_len;
      swa_rsp_type                    pending_averages [$];
      int                             errors;

      function new();
         wr_ptr     = '0;
         fill       = '0;
         sum        = '0;
         window_len = WINDOW_LEN_RESET;
         errors     = 0;
      endfunction

      function void set_window(logic [LEN_WIDTH-1:0] value);
         window_len = value;
      endfunction

      function int window_samples();
         if (window_len == 0) return 1;
         if (window_len > WINDOW_MAX) return WINDOW_MAX;
         return int'(window_len);
      endfunction

      function int pending();
         return pending_averages.size();
      endfunction

      function logic signed [AVG_WIDTH-1:0] scaled_mean(logic [LEN_WIDTH-1:0] len);
         longint s;
         longint q;
         s = longint'($signed(sum));
         q = (s * (longint'(1) << FRAC_BITS)) / longint'(len);
         if (q > 64'sd8388607) q = 64'sd8388607;
         if (q < -64'sd8388608) q = -64'sd8388608;
         return q[AVG_WIDTH-1:0];
      endfunction

      function void take_sample(swa_req_type item);
         logic [LEN_WIDTH-1:0] len;
         logic [PTR_WIDTH-1:0] oldest;
         logic [SUM_WIDTH-1:0] x;
         swa_rsp_type          res;
         bit                   produced;
         len      = LEN_WIDTH'(window_samples());
         x        = {{(SUM_WIDTH - SAMPLE_WIDTH){item.sample[SAMPLE_WIDTH-1]}}, item.sample};
         produced = 0;
         res      = '0;
         if (item.first_of_sequence) begin
            fill = '0;
            sum  = '0;
         end
         if (fill < len) begin
            sum  = sum + x;
            fill = fill + LEN_WIDTH'(1);
            if (fill == len) begin
               res.average = scaled_mean(len);
               produced    = 1;
            end
         end else begin
            // drop the sample that leaves the window; it lies len entries back
            oldest = wr_ptr - len[PTR_WIDTH-1:0];
            sum = sum - {{(SUM_WIDTH - SAMPLE_WIDTH){ring[oldest][SAMPLE_WIDTH-1]}},
                         ring[oldest]} + x;
            res.average = scaled_mean(len);
            produced    = 1;
         end
         ring[wr_ptr] = item.sample;
         wr_ptr       = wr_ptr + PTR_WIDTH'(1);
         if (item.last_of_sequence) begin
            if (fill < len) begin
               res.average   = '0;
               res.too_short = 1'b1;
               produced      = 1;
            end
            fill = '0;
            sum  = '0;
         end
         if (produced) pending_averages = {pending_averages, res};
      endfunction

      function void check_average(swa_rsp_type got);
         swa_rsp_type want;
         if (pending_averages.size() == 0) begin
            $display("%0t: result with none awaited: expected none, got average %0d too_short %0b",
                     $time, got.average, got.too_short);
            errors++;
            return;
         end
         want = pending_averages.pop_front();
         if (got.average !== want.average) begin
            $display("%0t: average expected %0d got %0d", $time, want.average, got.average);
            errors++;
         end
         if (got.too_short !== want.too_short) begin
            $display("%0t: too_short expected %0b got %0b", $time, want.too_short,
                     got.too_short);
            errors++;
         end
      endfunction
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   swa_req_type          req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   swa_rsp_type          rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [LEN_WIDTH-1:0] csr_wr_data = '0;

   moving_average_predictor sb;
   bit no_gaps      = 0;
   bit hold_request = 0;
   int random_sent  = 0;

   sliding_window_average u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("sliding_window_average: mismatch");
      $finish;
   end

   // note inputs before results so an edge carrying both is ordered
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (req_valid && req_ready) sb.take_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_average(rsp_data);
      end
   end

   // result side: random stall per transaction, long hold-off on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_WIDTH'($urandom_range(0, 100)) - 16'sd50;
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   task automatic send_sample(input swa_req_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_fields(input logic signed [SAMPLE_WIDTH-1:0] s, input logic f,
                              input logic l);
      swa_req_type item;
      item.sample            = s;
      item.first_of_sequence = f;
      item.last_of_sequence  = l;
      send_sample(item);
   endtask

   // let the monitor note the last transaction, drain results, then let a
   // sample without result finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input int w);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LEN_WIDTH'(w);
      sb.set_window(LEN_WIDTH'(w));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int w, input int budget);
      int          e;
      int          sent;
      int          seq_len;
      int          k;
      swa_req_type item;
      write_window(w);
      e    = sb.window_samples();
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 9))
            0, 1: seq_len = (e > 1) ? $urandom_range(1, e - 1) : 1;
            2: seq_len = e;
            default: seq_len = e + $urandom_range(0, 2 * e + 4);
         endcase
         // a sequence cut by the budget carries over into the next setting
         for (k = 0; k < seq_len && sent < budget; k++) begin
            item.sample            = pick_sample();
            item.first_of_sequence = (k == 0) ? ($urandom_range(0, 4) != 0) : 1'b0;
            item.last_of_sequence  = (k == seq_len - 1);
            if ($urandom_range(0, 9) == 0) begin
               item.first_of_sequence = 1'($urandom_range(0, 1));
               item.last_of_sequence  = 1'($urandom_range(0, 1));
            end
            send_sample(item);
            sent++;
         end
      end
      random_sent += sent;
      settle();
   endtask

   initial begin
      int plan [8];
      int i;
      int w;
      sb   = new();
      plan = '{1, 64, 0, 127, 2, 65, 3, 63};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset window of five: positive extreme, then slide in both extremes
      send_fields(16'sh7FFF, 1'b1, 1'b0);
      repeat (4) send_fields(16'sh7FFF, 1'b0, 1'b0);
      send_fields(16'sh7FFF, 1'b0, 1'b0);
      send_fields(16'sh8000, 1'b0, 1'b1);
      // negative extreme, window fills on the last sample
      send_fields(16'sh8000, 1'b1, 1'b0);
      repeat (3) send_fields(16'sh8000, 1'b0, 1'b0);
      send_fields(16'sh8000, 1'b0, 1'b1);
      // too short, started by the previous end alone
      send_fields(16'sh0000, 1'b0, 1'b0);
      send_fields(16'sh0001, 1'b0, 1'b0);
      send_fields(-16'sh0001, 1'b0, 1'b1);
      send_fields(-16'sh0001, 1'b1, 1'b1);
      // restart mid-sequence, leave it open for the next window length
      send_fields(16'sd100, 1'b1, 1'b0);
      send_fields(16'sd200, 1'b0, 1'b0);
      send_fields(16'sd300, 1'b0, 1'b0);
      send_fields(-16'sd7, 1'b1, 1'b0);
      repeat (4) send_fields(16'sd5, 1'b0, 1'b0);
      settle();

      for (i = 0; i < 8; i++) begin
         no_gaps = (i < 2) || ($urandom_range(0, 3) == 0);
         if (i < 2) hold_request = 1;
         run_phase(plan[i], (plan[i] >= 63) ? 160 : 70);
      end
      while (random_sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         w = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 127);
         run_phase(w, 60);
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("sliding_window_average: match");
      end else begin
         $display("sliding_window_average: mismatch");
      end
      $finish;
   end
endmodule
